### rtl/gradient_phase_atan2_assert.svh
// Assertion macros shared by the gradient phase RTL.
`ifndef GRADIENT_PHASE_ATAN2_ASSERT_SVH
`define GRADIENT_PHASE_ATAN2_ASSERT_SVH
`ifndef SYNTHESIS
// Checked only while reset is released.
`define GPA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gradient_phase_atan2: assertion failed");
// Checked at every edge, including during reset.
`define GPA_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("gradient_phase_atan2: assertion failed");
`else
`define GPA_ASSERT(label, clk, rst_n, prop)
`define GPA_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### rtl/gpa_pkg.sv
// Constants, types and helper functions of the gradient phase pipeline.
`timescale 1ns / 1ps
`default_nettype none

package gpa_pkg;

    localparam int GRADIENT_BITS = 16;
    localparam int GRAD_W        = 16;
    localparam int MAG_W         = GRADIENT_BITS;
    localparam int FRAC_BITS     = 16;
    localparam int Q_W           = FRAC_BITS + 1;
    localparam int DIV_STAGES    = Q_W;
    localparam int PHASE_W       = 8;
    localparam int ACC_W         = PHASE_W + FRAC_BITS;
    localparam int PROD_W        = ACC_W + Q_W + 1;

    localparam int COEF_P1_INT = 2669610;
    localparam int COEF_P3_INT = -869966;
    localparam int COEF_P5_INT = 415423;
    localparam int COEF_P7_INT = -118360;

    localparam logic signed [ACC_W-1:0] COEF_P1 = ACC_W'(COEF_P1_INT);
    localparam logic signed [ACC_W-1:0] COEF_P3 = ACC_W'(COEF_P3_INT);
    localparam logic signed [ACC_W-1:0] COEF_P5 = ACC_W'(COEF_P5_INT);
    localparam logic signed [ACC_W-1:0] COEF_P7 = ACC_W'(COEF_P7_INT);

    localparam logic [ACC_W-1:0] ANGLE_QUARTER = ACC_W'(64 << FRAC_BITS);
    localparam logic [ACC_W-1:0] ANGLE_HALF    = ACC_W'(128 << FRAC_BITS);
    localparam logic [ACC_W-1:0] HALF_LSB      = ACC_W'(1 << (FRAC_BITS - 1));

    // Reflections that are applied to the octant angle at the end.
    typedef struct packed {
        logic swap;
        logic neg_x;
        logic neg_y;
    } t_octant;

    // floor(a * b / 2^16) with b unsigned; the part-select of the signed
    // product is an arithmetic shift, which rounds toward minus infinity.
    function automatic logic signed [ACC_W-1:0] qmul(
        input logic signed [ACC_W-1:0] a,
        input logic [Q_W-1:0]          b
    );
        logic signed [PROD_W-1:0] p;
        p = a * $signed({1'b0, b});
        return p[FRAC_BITS +: ACC_W];
    endfunction

endpackage

`default_nettype wire

### rtl/gpa_divider.sv
// Pipelined restoring divider: one quotient bit per register stage.
`timescale 1ns / 1ps
`default_nettype none
`include "gradient_phase_atan2_assert.svh"

module gpa_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [gpa_pkg::MAG_W-1:0] i_num,
    input  logic [gpa_pkg::MAG_W-1:0] i_den,
    input  gpa_pkg::t_octant          i_oct,
    output logic                      o_valid,
    output logic [gpa_pkg::Q_W-1:0]   o_quo,
    output gpa_pkg::t_octant          o_oct
);

    logic                      r_valid [gpa_pkg::DIV_STAGES];
    logic [gpa_pkg::MAG_W-1:0] r_rem   [gpa_pkg::DIV_STAGES];
    logic [gpa_pkg::MAG_W-1:0] r_den   [gpa_pkg::DIV_STAGES];
    logic [gpa_pkg::Q_W-1:0]   r_quo   [gpa_pkg::DIV_STAGES];
    gpa_pkg::t_octant          r_oct   [gpa_pkg::DIV_STAGES];

    logic [gpa_pkg::MAG_W-1:0] n_rem   [gpa_pkg::DIV_STAGES];
    logic [gpa_pkg::Q_W-1:0]   n_quo   [gpa_pkg::DIV_STAGES];

    // The first stage sees the numerator itself (quotient bit 16 is set only
    // for equal magnitudes); each later stage doubles the remainder, which
    // always stays below the divisor.
    always_comb begin
        logic [gpa_pkg::MAG_W:0] part;
        logic [gpa_pkg::MAG_W:0] diff;
        logic                    ge;
        part     = {1'b0, i_num};
        diff     = part - {1'b0, i_den};
        ge       = part >= {1'b0, i_den};
        n_rem[0] = ge ? diff[gpa_pkg::MAG_W-1:0] : part[gpa_pkg::MAG_W-1:0];
        n_quo[0] = {{(gpa_pkg::Q_W-1){1'b0}}, ge};
        for (int k = 1; k < gpa_pkg::DIV_STAGES; k++) begin
            part     = {r_rem[k-1], 1'b0};
            diff     = part - {1'b0, r_den[k-1]};
            ge       = part >= {1'b0, r_den[k-1]};
            n_rem[k] = ge ? diff[gpa_pkg::MAG_W-1:0] : part[gpa_pkg::MAG_W-1:0];
            n_quo[k] = {r_quo[k-1][gpa_pkg::Q_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < gpa_pkg::DIV_STAGES; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < gpa_pkg::DIV_STAGES; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_den;
            r_oct[0] <= i_oct;
            for (int k = 1; k < gpa_pkg::DIV_STAGES; k++) begin
                r_den[k] <= r_den[k-1];
                r_oct[k] <= r_oct[k-1];
            end
            for (int k = 0; k < gpa_pkg::DIV_STAGES; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
            end
        end
    end

    assign o_valid = r_valid[gpa_pkg::DIV_STAGES-1];
    assign o_quo   = r_quo[gpa_pkg::DIV_STAGES-1];
    assign o_oct   = r_oct[gpa_pkg::DIV_STAGES-1];

    // A ratio of exactly one carries no fraction bits.
    `GPA_ASSERT(a_quo_at_most_one, i_clk, i_rst_n, o_valid && o_quo[gpa_pkg::Q_W-1] |-> o_quo[gpa_pkg::Q_W-2:0] == '0)

endmodule

`default_nettype wire

### rtl/gpa_poly.sv
// Horner evaluation of the odd 7th-order arctangent polynomial, one product per stage.
`timescale 1ns / 1ps
`default_nettype none

module gpa_poly (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [gpa_pkg::Q_W-1:0]          i_c,
    input  gpa_pkg::t_octant                 i_oct,
    output logic                             o_valid,
    output logic signed [gpa_pkg::ACC_W-1:0] o_angle,
    output gpa_pkg::t_octant                 o_oct
);

    localparam int POLY_STAGES = 5;

    logic                             r_valid [POLY_STAGES];
    gpa_pkg::t_octant                 r_oct   [POLY_STAGES];
    logic [gpa_pkg::Q_W-1:0]          r_c     [POLY_STAGES-1];
    logic [gpa_pkg::Q_W-1:0]          r_c2    [POLY_STAGES-2];
    logic signed [gpa_pkg::ACC_W-1:0] r_a1;
    logic signed [gpa_pkg::ACC_W-1:0] r_a2;
    logic signed [gpa_pkg::ACC_W-1:0] r_a3;
    logic signed [gpa_pkg::ACC_W-1:0] r_a4;

    logic [2*gpa_pkg::Q_W-1:0] sq;
    logic [gpa_pkg::Q_W-1:0]   n_c2;

    assign sq   = i_c * i_c;
    assign n_c2 = sq[gpa_pkg::FRAC_BITS +: gpa_pkg::Q_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < POLY_STAGES; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < POLY_STAGES; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_oct[0] <= i_oct;
            for (int k = 1; k < POLY_STAGES; k++) begin
                r_oct[k] <= r_oct[k-1];
            end
            r_c[0] <= i_c;
            for (int k = 1; k < POLY_STAGES - 1; k++) begin
                r_c[k] <= r_c[k-1];
            end
            r_c2[0] <= n_c2;
            for (int k = 1; k < POLY_STAGES - 2; k++) begin
                r_c2[k] <= r_c2[k-1];
            end
            r_a1 <= gpa_pkg::qmul(gpa_pkg::COEF_P7, r_c2[0]) + gpa_pkg::COEF_P5;
            r_a2 <= gpa_pkg::qmul(r_a1, r_c2[1]) + gpa_pkg::COEF_P3;
            r_a3 <= gpa_pkg::qmul(r_a2, r_c2[2]) + gpa_pkg::COEF_P1;
            r_a4 <= gpa_pkg::qmul(r_a3, r_c[3]);
        end
    end

    assign o_valid = r_valid[POLY_STAGES-1];
    assign o_angle = r_a4;
    assign o_oct   = r_oct[POLY_STAGES-1];

endmodule

`default_nettype wire

### rtl/gradient_phase_atan2.sv
// Gradient phase unit: signed x/y gradients in, 8-bit direction phase out.
//
// Input channel: i_valid / o_ready with i_grad_x and i_grad_y (two's
// complement). Output channel: o_valid / i_ready with o_phase, 256 units
// per full turn. A transfer happens on a rising edge with valid and ready
// both high on that channel.
// From input transfer to o_valid an item passes one magnitude stage,
// 17 divider stages (one quotient bit each), 5 multiply stages of the
// polynomial, one reflection stage and the rounding output register.
// Throughput is one item per cycle while the output does not stall; the
// divider and multiplier stages are all fully pipelined.
// All stages advance together. When o_valid is high and i_ready is low the
// whole pipeline holds, o_ready drops, and o_phase stays unchanged; nothing
// is dropped or repeated. Bubbles are not squeezed out during a stall.
// Reset (i_rst_n low at a clock edge) empties the pipeline; the unit takes
// items again in the first cycle after reset is released.
`timescale 1ns / 1ps
`default_nettype none
`include "gradient_phase_atan2_assert.svh"

module gradient_phase_atan2 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [gpa_pkg::GRAD_W-1:0] i_grad_x,
    input  logic signed [gpa_pkg::GRAD_W-1:0] i_grad_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [gpa_pkg::PHASE_W-1:0]   o_phase
);

    logic advance;

    logic                      r_mag_valid;
    logic [gpa_pkg::MAG_W-1:0] r_mn;
    logic [gpa_pkg::MAG_W-1:0] r_mx;
    gpa_pkg::t_octant          r_mag_oct;

    logic [gpa_pkg::MAG_W-1:0] gx;
    logic [gpa_pkg::MAG_W-1:0] gy;
    logic [gpa_pkg::MAG_W-1:0] ax;
    logic [gpa_pkg::MAG_W-1:0] ay;
    logic [gpa_pkg::MAG_W-1:0] n_mn;
    logic [gpa_pkg::MAG_W-1:0] n_mx;
    gpa_pkg::t_octant          n_mag_oct;

    logic                      div_valid;
    logic [gpa_pkg::Q_W-1:0]   div_quo;
    gpa_pkg::t_octant          div_oct;

    logic                             poly_valid;
    logic signed [gpa_pkg::ACC_W-1:0] poly_angle;
    gpa_pkg::t_octant                 poly_oct;

    logic                      r_fold_valid;
    logic [gpa_pkg::ACC_W-1:0] r_fold;
    logic [gpa_pkg::ACC_W-1:0] fold_sw;
    logic [gpa_pkg::ACC_W-1:0] fold_nx;
    logic [gpa_pkg::ACC_W-1:0] n_fold;
    logic [gpa_pkg::ACC_W-1:0] rounded;

    logic                        r_out_valid;
    logic [gpa_pkg::PHASE_W-1:0] r_phase;

    assign advance = i_ready || !r_out_valid;
    assign o_ready = advance;

    // Only the low GRADIENT_BITS bits count; the top one of them is the sign.
    assign gx = i_grad_x[gpa_pkg::GRADIENT_BITS-1:0];
    assign gy = i_grad_y[gpa_pkg::GRADIENT_BITS-1:0];
    assign ax = gx[gpa_pkg::MAG_W-1] ? (~gx + 1'b1) : gx;
    assign ay = gy[gpa_pkg::MAG_W-1] ? (~gy + 1'b1) : gy;

    always_comb begin
        n_mag_oct.swap  = ay > ax;
        n_mag_oct.neg_x = gx[gpa_pkg::MAG_W-1];
        n_mag_oct.neg_y = gy[gpa_pkg::MAG_W-1];
        n_mn = n_mag_oct.swap ? ax : ay;
        n_mx = n_mag_oct.swap ? ay : ax;
        // A zero vector divides 0 by 1, which gives the zero ratio directly.
        if (n_mx == '0) begin
            n_mx = gpa_pkg::MAG_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag_valid <= 1'b0;
        end else if (advance) begin
            r_mag_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_mn      <= n_mn;
            r_mx      <= n_mx;
            r_mag_oct <= n_mag_oct;
        end
    end

    gpa_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_valid (r_mag_valid),
        .i_num   (r_mn),
        .i_den   (r_mx),
        .i_oct   (r_mag_oct),
        .o_valid (div_valid),
        .o_quo   (div_quo),
        .o_oct   (div_oct)
    );

    gpa_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_valid (div_valid),
        .i_c     (div_quo),
        .i_oct   (div_oct),
        .o_valid (poly_valid),
        .o_angle (poly_angle),
        .o_oct   (poly_oct)
    );

    // Reflections work modulo one full turn, so the last one is a negation.
    assign fold_sw = poly_oct.swap  ? (gpa_pkg::ANGLE_QUARTER - poly_angle) : poly_angle;
    assign fold_nx = poly_oct.neg_x ? (gpa_pkg::ANGLE_HALF - fold_sw) : fold_sw;
    assign n_fold  = poly_oct.neg_y ? (~fold_nx + 1'b1) : fold_nx;

    assign rounded = r_fold + gpa_pkg::HALF_LSB;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else if (advance) begin
            r_fold_valid <= poly_valid;
            r_out_valid  <= r_fold_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_fold  <= n_fold;
            r_phase <= rounded[gpa_pkg::FRAC_BITS +: gpa_pkg::PHASE_W];
        end
    end

    assign o_valid = r_out_valid;
    assign o_phase = r_phase;

    `GPA_ASSERT(a_min_below_max, i_clk, i_rst_n, r_mag_valid |-> r_mn <= r_mx)
    `GPA_ASSERT(a_divisor_nonzero, i_clk, i_rst_n, r_mag_valid |-> r_mx != '0)
    `GPA_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_valid && !r_fold_valid)

endmodule

`default_nettype wire
